// ===== design/kpi_pkg.sv =====
package kpi_pkg;

  localparam int MaxFramesDefault = 128;
  localparam int FracBitsDefault  = 16;
  localparam int ValW             = 32;
  localparam int NumChan          = 9;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_RESET = 2'd1,
    KIND_START = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_ACK      = 2'd0,
    ST_POSE     = 2'd1,
    ST_FINISHED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_START_X = 1'd0,
    REG_START_Z = 1'd1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_START_RD,
    S_START_WAIT,
    S_SEARCH_RD,
    S_SEARCH_WAIT,
    S_SEARCH_CHK,
    S_PAIR_RD,
    S_PAIR_WAIT,
    S_PAIR_CAP,
    S_DIV,
    S_BLEND,
    S_OUT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;     // latch the input item
    logic write_frame; // append frame at frame_count
    logic clear_table; // zero count and clock
    logic rd_first;    // read address zero
    logic rd_idx;      // read address idx
    logic rd_prev;     // read address idx - 1
    logic set_clock;   // clock from read time
    logic add_dt;      // clock plus dt
    logic init_search; // idx to one
    logic step_search; // idx plus one
    logic cap_q;       // keep q row
    logic cap_p;       // keep p row
    logic div_start;
    logic blend_start;
    logic out_load;
    status_t out_status;
  } kpi_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic    full;
    logic    search_end;  // idx reached count
    logic    found;       // clock below time at idx
    logic    div_done;
    logic    blend_done;
    logic    out_busy;
    kind_t   kind;
  } kpi_stat_t;

endpackage

// ===== design/kpi_ram.sv =====
module kpi_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== design/kpi_ctrl.sv =====
module kpi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kpi_pkg::kpi_stat_t st,
  output kpi_pkg::kpi_cmd_t  cmd
);
  import kpi_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_LOAD;
      S_LOAD: begin
        case (st.kind)
          KIND_LOAD:  state_next = S_OUT;
          KIND_RESET: state_next = S_OUT;
          KIND_START: state_next = S_START_RD;
          default:    state_next = S_SEARCH_RD;
        endcase
      end
      S_START_RD:    state_next = S_START_WAIT;
      S_START_WAIT:  state_next = S_OUT;
      S_SEARCH_RD:   state_next = st.search_end ? S_OUT : S_SEARCH_WAIT;
      S_SEARCH_WAIT: state_next = S_SEARCH_CHK;
      S_SEARCH_CHK:  state_next = st.found ? S_PAIR_RD : S_SEARCH_RD;
      S_PAIR_RD:     state_next = S_PAIR_WAIT;
      S_PAIR_WAIT:   state_next = S_PAIR_CAP;
      S_PAIR_CAP:    state_next = S_DIV;
      S_DIV:         if (st.div_done) state_next = S_BLEND;
      S_BLEND:       if (st.blend_done) state_next = S_OUT;
      S_OUT:         if (!st.out_busy) state_next = S_IDLE;
      default:       state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    cmd.out_status = ST_ACK;
    in_ready = (state == S_IDLE);
    case (state)
      S_IDLE: cmd.capture = in_valid;
      S_LOAD: begin
        case (st.kind)
          KIND_LOAD:  cmd.write_frame = !st.full;
          KIND_RESET: cmd.clear_table = 1'b1;
          KIND_START: cmd.rd_first = 1'b1;
          default: begin
            cmd.add_dt = 1'b1;
            cmd.init_search = 1'b1;
          end
        endcase
      end
      // hold the read address on entry zero until the clock takes it
      S_START_RD:    cmd.rd_first = 1'b1;
      S_START_WAIT:  cmd.set_clock = 1'b1;
      S_SEARCH_RD:   cmd.rd_idx = 1'b1;
      S_SEARCH_CHK: begin
        cmd.step_search = !st.found;
        cmd.rd_idx = 1'b1;
      end
      // keep the found row, then the one before it
      S_PAIR_RD: begin
        cmd.rd_prev = 1'b1;
        cmd.cap_q = 1'b1;
      end
      S_PAIR_WAIT:   cmd.cap_p = 1'b1;
      S_PAIR_CAP:    cmd.div_start = 1'b1;
      S_DIV:         cmd.blend_start = st.div_done;
      S_OUT:         cmd.out_load = !st.out_busy;
      default: ;
    endcase
    // status of the result
    case (st.kind)
      KIND_LOAD: cmd.out_status = st.full ? ST_FULL : ST_ACK;
      KIND_TICK: cmd.out_status = st.search_end ? ST_FINISHED : ST_POSE;
      default:   cmd.out_status = ST_ACK;
    endcase
  end

  a_in_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_blend_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_BLEND) |-> ($past(state) == S_BLEND || $past(state) == S_DIV))
    else $error("blend entered out of order");
  a_one_out: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> state == S_IDLE) else $error("result not closed");
endmodule

// ===== design/kpi_datapath.sv =====
module kpi_datapath #(
  parameter int MaxFrames = kpi_pkg::MaxFramesDefault,
  parameter int FracBits  = kpi_pkg::FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [1:0]         in_kind,
  input  logic [11*32-1:0]   in_vals,
  input  kpi_pkg::kpi_cmd_t  cmd,
  output kpi_pkg::kpi_stat_t st,
  output logic               m_valid,
  input  logic               m_ready,
  output logic [1:0]         m_status,
  output logic [9*32-1:0]    m_pose
);
  import kpi_pkg::*;

  localparam int AW = $clog2(MaxFrames);
  localparam int CW = $clog2(MaxFrames + 1);
  localparam int PW = 64 + FracBits + 2;

  logic signed [31:0] start_x, start_z;
  kind_t              kind;
  logic [11*32-1:0]   vals;
  logic [CW-1:0]      frame_count;
  logic signed [31:0] key_time;
  logic [CW-1:0]      idx;
  logic               full_cap;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_z <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_START_X) start_x <= cfg_data;
      else                          start_z <= cfg_data;
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (rst) kind <= KIND_LOAD;
    else if (cmd.capture) begin
      kind <= kind_t'(in_kind);
      vals <= in_vals;
    end
  end

  // Hold whether the table was full when the item arrived
  always_ff @(posedge clk) begin
    if (rst) full_cap <= 1'b0;
    else if (cmd.capture) full_cap <= (frame_count == CW'(MaxFrames));
  end

  function automatic logic [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sd2147483647)       return 32'h7fffffff;
    else if (v < -33'sd2147483648) return 32'h80000000;
    else                           return v[31:0];
  endfunction

  // Row to be written: time, x, y, z, yaw, pitch, ls, rs, lh, rh
  logic signed [31:0] w_x, w_z;
  logic [10*32-1:0]   wrow;
  always_comb begin
    w_x = sat33(33'(signed'(vals[2*32 +: 32])) + 33'(start_x));
    w_z = sat33(33'(start_z) - 33'(signed'(vals[3*32 +: 32])));
    wrow = {vals[10*32 +: 32], vals[9*32 +: 32], vals[8*32 +: 32], vals[7*32 +: 32],
            vals[6*32 +: 32], vals[5*32 +: 32], w_z, vals[4*32 +: 32], w_x,
            vals[1*32 +: 32]};
  end

  logic [AW-1:0]    raddr, waddr;
  logic [10*32-1:0] rrow;
  always_comb begin
    waddr = frame_count[AW-1:0];
    if (cmd.rd_first)     raddr = '0;
    else if (cmd.rd_prev) raddr = AW'(idx - CW'(1));
    else                  raddr = idx[AW-1:0];
  end

  kpi_ram #(.Width(10*32), .Depth(MaxFrames)) u_ram (
    .clk(clk), .we(cmd.write_frame), .waddr(waddr), .wdata(wrow),
    .raddr(raddr), .rdata(rrow)
  );

  logic signed [32:0] kt_sum;
  assign kt_sum = 33'(key_time) + 33'(signed'(vals[1*32 +: 32]));

  // Count, clock and search index
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      key_time <= '0;
      idx <= '0;
    end else begin
      if (cmd.write_frame) frame_count <= frame_count + CW'(1);
      if (cmd.clear_table) begin
        frame_count <= '0;
        key_time <= '0;
      end
      if (cmd.set_clock) key_time <= rrow[31:0];
      if (cmd.add_dt) key_time <= sat33(kt_sum);
      if (cmd.init_search) idx <= CW'(1);
      if (cmd.step_search) idx <= idx + CW'(1);
    end
  end

  logic [10*32-1:0] row_q, row_p;
  always_ff @(posedge clk) begin
    if (cmd.cap_q) row_q <= rrow;
    if (cmd.cap_p) row_p <= rrow;
  end

  // Fraction: restoring divider, one quotient bit a cycle
  logic signed [32:0] num, den;
  logic [32:0]        an, ad, rem;
  logic [32:0]        rem_d;
  logic [FracBits+1:0] quo;
  logic [5:0]          dcnt;
  logic                div_busy, div_done;
  logic [FracBits:0]   frac;
  logic [33:0]         rem2;
  assign num = 33'(key_time) - 33'(signed'(row_q[31:0]));
  assign den = 33'(signed'(row_p[31:0])) - 33'(signed'(row_q[31:0]));
  assign an = num[32] ? 33'(-num) : 33'(num);
  assign ad = den[32] ? 33'(-den) : 33'(den);
  assign rem2 = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      if (cmd.div_start) begin
        if (den == 0 || (an != 0 && num[32] == den[32] && an >= ad)) begin
          frac <= (FracBits+1)'(1) << FracBits;
          div_done <= 1'b1;
        end else if (an == 0 || num[32] != den[32]) begin
          frac <= '0;
          div_done <= 1'b1;
        end else begin
          rem <= an;
          quo <= '0;
          dcnt <= 6'(FracBits + 1);
          div_busy <= 1'b1;
          // save divisor
          rem_d <= ad;
        end
      end else if (div_busy) begin
        if (dcnt == 0) begin
          // round: quotient has one extra bit
          frac <= (FracBits+1)'((quo + (FracBits+2)'(1)) >> 1);
          div_busy <= 1'b0;
          div_done <= 1'b1;
        end else begin
          dcnt <= dcnt - 6'd1;
          if (rem2 >= {1'b0, rem_d}) begin
            rem <= 33'(rem2 - {1'b0, rem_d});
            quo <= {quo[FracBits:0], 1'b1};
          end else begin
            rem <= rem2[32:0];
            quo <= {quo[FracBits:0], 1'b0};
          end
        end
      end
    end
  end

  // Blend: one channel at a time through one multiplier and a register, each channel finished before the next begins
  logic [3:0]          bch;
  logic                bbusy, bmul, bdone;
  logic signed [32:0]  diff;
  logic signed [PW-1:0] prod;
  logic signed [31:0]  vq;
  logic [9*32-1:0]     pose;
  logic signed [PW-1:0] s;
  logic signed [PW-1:0] qv;
  logic signed [PW-1:0] tot;

  assign diff = 33'(signed'(row_p[(bch+1)*32 +: 32])) - 33'(signed'(row_q[(bch+1)*32 +: 32]));

  always_comb begin
    s = prod + (PW'(1) <<< (FracBits - 1));
    qv = s >>> FracBits;
    tot = PW'(vq) + qv;
    if (tot > PW'(32'sh7fffffff))       qv = PW'(32'sh7fffffff);
    else if (tot < -PW'(64'sh80000000)) qv = -PW'(64'sh80000000);
    else                                 qv = tot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bbusy <= 1'b0;
      bmul <= 1'b0;
      bdone <= 1'b0;
    end else begin
      bdone <= 1'b0;
      if (cmd.blend_start) begin
        bbusy <= 1'b1;
        bch <= '0;
        bmul <= 1'b0;
      end else if (bbusy) begin
        if (!bmul) begin
          prod <= PW'(diff) * PW'(signed'({1'b0, frac}));
          vq <= row_q[(bch+1)*32 +: 32];
          bmul <= 1'b1;
        end else begin
          pose[bch*32 +: 32] <= qv[31:0];
          bmul <= 1'b0;
          if (bch == 4'(NumChan - 1)) begin
            bbusy <= 1'b0;
            bdone <= 1'b1;
          end else bch <= bch + 4'd1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) m_valid <= 1'b0;
    else begin
      if (m_valid && m_ready) m_valid <= 1'b0;
      if (cmd.out_load) begin
        m_valid <= 1'b1;
        m_status <= cmd.out_status;
        m_pose <= (cmd.out_status == ST_POSE) ? pose : '0;
      end
    end
  end

  assign st.full       = full_cap;
  assign st.search_end = (idx >= frame_count);
  assign st.found      = (key_time < signed'(rrow[31:0]));
  assign st.div_done   = div_done;
  assign st.blend_done = bdone;
  assign st.out_busy   = m_valid && !m_ready;
  assign st.kind       = kind;

  a_count: assert property (@(posedge clk) disable iff (rst)
    frame_count <= CW'(MaxFrames)) else $error("count overflow");
  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    cmd.write_frame |-> !st.full) else $error("write into full table");
  a_frac: assert property (@(posedge clk) disable iff (rst)
    div_done |=> frac <= ((FracBits+1)'(1) << FracBits)) else $error("frac range");
endmodule

// ===== design/keyframe_pose_interpolator.sv =====
// Keyframe pose interpolator. One result item per input item: load, reset
// and start finish without a search; a tick walks the table entries one
// at a time by a linear search through the frame memory (one read port)
// and, when it finds a segment, yields a pose. The divider yields one
// fraction bit a cycle and skips the division when the fraction is 0 or
// 1, and the nine channels share one multiplier, one channel at a time.
// A stalled result holds the block until it is taken. No clearing pass
// follows reset.
module keyframe_pose_interpolator #(
  parameter int MAX_FRAMES = kpi_pkg::MaxFramesDefault,
  parameter int FRAC_BITS  = kpi_pkg::FracBitsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // time_value, in_x, in_z, in_y, in_yaw, in_pitch, in_left_shoulder,
  // in_right_shoulder, in_left_hip, in_right_hip
  input  logic [319:0] s_tdata,
  // kind
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x, pos_y, pos_z, yaw, pitch, left_shoulder, right_shoulder,
  // left_hip, right_hip
  output logic [287:0] m_tdata,
  // status
  output logic [1:0]   m_tuser
);
  import kpi_pkg::*;

  kpi_cmd_t  cmd;
  kpi_stat_t st;

  kpi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .st(st), .cmd(cmd)
  );

  kpi_datapath #(.MaxFrames(MAX_FRAMES), .FracBits(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_kind(s_tuser), .in_vals({s_tdata, 32'd0}),
    .cmd(cmd), .st(st), .m_valid(m_tvalid), .m_ready(m_tready),
    .m_status(m_tuser), .m_pose(m_tdata)
  );
endmodule

// ===== verif/keyframe_pose_interpolator_tb.sv =====
`timescale 1ns / 100ps

module keyframe_pose_interpolator_tb;
  import kpi_pkg::*;

  localparam int MaxFr = 128;
  localparam int FracW = 16;
  localparam longint OneFrac = 64'sd1 << FracW;
  localparam int CycleLimit = 2000000;

  typedef logic signed [31:0] val_t;

  typedef struct {
    status_t st;
    val_t    ch[9];
  } pose_res_t;

  // Saturate a wide sum back to 32 bits
  function automatic val_t clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return val_t'(v);
  endfunction

  // Blend weight in Q.FracW, clamped to [0, 1]
  function automatic longint seg_weight(longint num, longint den);
    longint an, ad, f;
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    if (an == 0) return 0;
    if ((num < 0) != (den < 0)) return 0;
    if (an >= ad) return OneFrac;
    f = ((an <<< FracW) + ad / 2) / ad;
    return f > OneFrac ? OneFrac : f;
  endfunction

  function automatic val_t mix_chan(longint w, val_t vp, val_t vq);
    longint s, q;
    s = (longint'(vp) - longint'(vq)) * w + (OneFrac >>> 1);
    if (s >= 0) q = s >>> FracW;
    else q = -((-s + OneFrac - 1) >>> FracW);
    return clip32(longint'(vq) + q);
  endfunction

  class pose_scoreboard;
    val_t off_x, off_z, clock_t;
    val_t key_tm[MaxFr];
    val_t key_ch[MaxFr][9];
    int count;
    pose_res_t pending[$];
    int errors;

    function new();
      off_x = 0; off_z = 0; clock_t = 0; count = 0; errors = 0;
    endfunction

    function void set_reg(reg_idx_t r, val_t v);
      if (r == REG_START_X) off_x = v;
      else off_z = v;
    endfunction

    // Predict the result of one accepted input item
    function void note_input(kind_t k, val_t tv, val_t f[9]);
      pose_res_t r;
      int idx;
      longint w, den;
      r.st = ST_ACK;
      foreach (r.ch[j]) r.ch[j] = 0;
      case (k)
        KIND_LOAD: begin
          if (count >= MaxFr) r.st = ST_FULL;
          else begin
            key_tm[count] = tv;
            key_ch[count][0] = clip32(longint'(f[0]) + off_x);
            key_ch[count][1] = f[2];
            key_ch[count][2] = clip32(longint'(off_z) - f[1]);
            for (int j = 3; j < 9; j++) key_ch[count][j] = f[j];
            count++;
          end
        end
        KIND_RESET: begin
          count = 0; clock_t = 0;
        end
        KIND_START: clock_t = key_tm[0];
        default: begin
          clock_t = clip32(longint'(clock_t) + tv);
          for (idx = 1; idx < count; idx++)
            if (clock_t < key_tm[idx]) break;
          if (count == 0 || idx >= count) r.st = ST_FINISHED;
          else begin
            den = longint'(key_tm[idx-1]) - key_tm[idx];
            w = den == 0 ? OneFrac : seg_weight(longint'(clock_t) - key_tm[idx], den);
            r.st = ST_POSE;
            for (int j = 0; j < 9; j++)
              r.ch[j] = mix_chan(w, key_ch[idx-1][j], key_ch[idx][j]);
          end
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [287:0] d);
      pose_res_t e;
      string names[9] = '{"pos_x", "pos_y", "pos_z", "yaw", "pitch", "left_shoulder",
                          "right_shoulder", "left_hip", "right_hip"};
      if (pending.size() == 0) begin
        $error("unexpected result item status=%0d", st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.st) begin
        $error("status expected %0d actual %0d", e.st, st);
        errors++;
      end
      for (int j = 0; j < 9; j++)
        if (d[32*j +: 32] !== e.ch[j]) begin
          $error("%s expected %0d actual %0d", names[j], e.ch[j], $signed(d[32*j +: 32]));
          errors++;
        end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [319:0] s_tdata = 0;
  logic [1:0] s_tuser = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [287:0] m_tdata;
  logic [1:0] m_tuser;

  pose_scoreboard sb;
  int cycles = 0;
  int burst_left = 0;
  bit stall_free = 0;

  always #1 clk = ~clk;

  keyframe_pose_interpolator dut (.*);

  // Receiver: stall on its own pattern, check every accepted result item
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    m_tready <= stall_free ? 1'b1 : (($urandom_range(0, 7) < 5) || (cycles % 97 < 20));
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic val_t rnd_val();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      default: return $urandom();
    endcase
  endfunction

  // Send one item; bursts and gaps shape the sender. Valid stays high
  // between items of a burst and drops only for a gap or a drain.
  task automatic send_item(kind_t k, val_t tv, val_t f[9]);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        s_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1;
    s_tuser <= k;
    s_tdata[31:0] <= tv;
    for (int j = 0; j < 9; j++) s_tdata[32*(j+1) +: 32] <= f[j];
    do @(posedge clk); while (!s_tready);
    sb.note_input(k, tv, f);
  endtask

  task automatic send_rnd_load(val_t tv);
    val_t f[9];
    foreach (f[j]) f[j] = rnd_val();
    send_item(KIND_LOAD, tv, f);
  endtask

  task automatic send_ctl(kind_t k, val_t tv);
    val_t f[9];
    foreach (f[j]) f[j] = $urandom();
    send_item(k, tv, f);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, val_t v);
    cfg_we <= 1; cfg_index <= r; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(r, v);
  endtask

  initial begin
    val_t t;
    int n;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, every kind, empty and single-frame ticks, equal times
    send_ctl(KIND_TICK, 100);
    send_rnd_load(32'sh7fffffff);
    send_ctl(KIND_TICK, 5);
    send_ctl(KIND_START, 0);
    send_rnd_load(32'sh7fffffff);
    send_ctl(KIND_TICK, 32'sh80000000);
    send_ctl(KIND_TICK, 32'sh7fffffff);
    send_ctl(KIND_TICK, 32'sh7fffffff);
    send_ctl(KIND_RESET, 0);
    send_rnd_load(32'sh80000000);
    send_rnd_load(0);
    send_rnd_load(32'sh00020000);
    send_ctl(KIND_START, 0);
    send_ctl(KIND_TICK, 32'sh00008000);
    send_ctl(KIND_TICK, 32'sh00018000);
    send_ctl(KIND_TICK, 32'sh00010000);
    send_ctl(KIND_TICK, -32'sh00030000);
    drain();

    // Offsets at the extremes, then fill the table past full
    write_reg(REG_START_X, 32'sh7fffffff);
    write_reg(REG_START_Z, 32'sh80000000);
    send_ctl(KIND_RESET, 0);
    for (int i = 0; i < MaxFr + 3; i++) begin
      if (i == MaxFr) stall_free = 1;
      send_rnd_load(i * 32'sh00004000);
    end
    stall_free = 0;
    send_ctl(KIND_START, 0);
    for (int i = 0; i < 20; i++) send_ctl(KIND_TICK, $urandom_range(0, 32'h00100000));
    drain();

    // Random phases: short well-formed tracks with noise
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_START_X, ph == 7 ? 32'sh80000000 : rnd_val());
      write_reg(REG_START_Z, ph == 7 ? 32'sh7fffffff : rnd_val());
      for (int s = 0; s < 4; s++) begin
        send_ctl(KIND_RESET, 0);
        n = $urandom_range(1, 6);
        t = $urandom_range(0, 32'h00100000) - 32'sh00080000;
        for (int i = 0; i < n; i++) begin
          send_rnd_load(t);
          if ($urandom_range(0, 5) == 0) t = t - $urandom_range(0, 32'h10000);
          else t = t + $urandom_range(0, 32'h00040000);
        end
        send_ctl(KIND_START, 0);
        repeat ($urandom_range(2, 8)) begin
          if ($urandom_range(0, 9) == 0) send_ctl(KIND_TICK, rnd_val());
          else send_ctl(KIND_TICK, $urandom_range(0, 32'h00030000));
          if ($urandom_range(0, 15) == 0) send_ctl(KIND_START, 0);
        end
      end
      drain();
    end

    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// ===== keyframe_pose_interpolator.f =====
design/kpi_pkg.sv
design/kpi_ram.sv
design/kpi_ctrl.sv
design/kpi_datapath.sv
design/keyframe_pose_interpolator.sv
verif/keyframe_pose_interpolator_tb.sv
